/* rtl/core/pppfr_pkg.sv */
// Package for the PPP async HDLC framer: line constants, FCS seed and the
// command record passed from the front end to the byte sequencer.
// No dependencies.
package pppfr_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ADDR_BYTE = 8'hFF;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  CTRL_ESC  = 8'h23;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] FCS_SEED  = 16'h3DE3;
  localparam logic [15:0] FCS_POLY  = 16'h8408;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // One classified payload request.
  typedef struct packed {
    logic [7:0]  data;     // payload byte
    logic        open;     // header goes out first
    logic        last;     // closes the frame
    logic [15:0] fcs;      // complemented FCS, meaningful when last
  } cmd_t;

endpackage

/* rtl/core/ppp_async_hdlc_framer.sv */
// PPP async HDLC framer, top level. An accepted request passes the queue and
// the sequencer's output register before its first line byte shows on the
// result ports. One line byte per cycle unless the queue is empty or a byte
// waits unpopped, set by the single output register of the sequencer. A plain
// payload byte yields 1 line byte, an escaped one 2, frame open +4, close +3 to 5.
// Reset (rst, synchronous): FCS back to seed, frame closed, queue and output empty.
module ppp_async_hdlc_framer import pppfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] payload_byte,
  input  logic       frame_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] line_byte,
  output logic       burst_last
);

  // Front end: take a request whenever the queue has room.
  logic accept;
  cmd_t front_cmd;

  // Queue head toward the sequencer.
  logic head_valid;
  cmd_t head_cmd;
  logic head_pop;

  assign accept = push && !full;

  // Classify the request and advance the running FCS at accept time, so the
  // FCS for a closing byte travels with its command.
  pppfr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .payload_byte (payload_byte),
    .frame_end    (frame_end),
    .cmd          (front_cmd)
  );

  // Hold up to four commands so input keeps flowing while the sequencer
  // works through a header or trailer.
  pppfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (accept),
    .wr_cmd     (front_cmd),
    .full       (full),
    .rd_en      (head_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Expand the head command into line bytes; drop it from the queue with its
  // final byte.
  pppfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .line_byte  (line_byte),
    .burst_last (burst_last)
  );

endmodule

/* rtl/core/pppfr_front.sv */
// Front end: accepts payload requests, updates the running FCS-16 and the
// frame-open flag, and hands a classified command to the queue.
// Depends on pppfr_pkg.
module pppfr_front import pppfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] payload_byte,
  input  logic       frame_end,
  output cmd_t       cmd
);

  logic [15:0] running_fcs;
  logic        inside_frame;
  logic [15:0] fcs_next;

  // Reflected CRC-16, one byte.
  function automatic logic [15:0] fcs_update(input logic [15:0] f_in,
                                             input logic [7:0] b);
    logic [15:0] f;
    f = f_in;
    for (int i = 0; i < 8; i++) begin
      if (f[0] ^ b[i]) f = (f >> 1) ^ FCS_POLY;
      else             f = f >> 1;
    end
    return f;
  endfunction

  assign fcs_next = fcs_update(running_fcs, payload_byte);

  always_comb begin
    cmd.data = payload_byte;
    cmd.open = !inside_frame;
    cmd.last = frame_end;
    cmd.fcs  = ~fcs_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_fcs  <= FCS_SEED;
      inside_frame <= 1'b0;
    end else if (accept) begin
      if (frame_end) begin
        running_fcs  <= FCS_SEED;
        inside_frame <= 1'b0;
      end else begin
        running_fcs  <= fcs_next;
        inside_frame <= 1'b1;
      end
    end
  end

endmodule

/* rtl/core/pppfr_queue.sv */
// Short command queue between front end and sequencer.
// Depends on pppfr_pkg.
module pppfr_queue import pppfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t             slots [QDepth];
  logic [QAw-1:0]   wr_ptr;
  logic [QAw-1:0]   rd_ptr;
  logic [QAw:0]     count;

  assign full       = (count == (QAw+1)'(QDepth));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      if (wr_en && !rd_en)      count <= count + 1'b1;
      else if (!wr_en && rd_en) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/core/pppfr_back.sv */
// Byte sequencer: walks header, stuffed payload, FCS and closing flag for
// the command at the queue head, one line byte per cycle into an output
// register while that register is free or popped. Depends on pppfr_pkg.
module pppfr_back import pppfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       head_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] line_byte,
  output logic       burst_last
);

  typedef enum logic [7:0] {
    ST_HDR0  = 8'b0000_0001,
    ST_HDR1  = 8'b0000_0010,
    ST_HDR2  = 8'b0000_0100,
    ST_HDR3  = 8'b0000_1000,
    ST_DATA  = 8'b0001_0000,
    ST_FCSLO = 8'b0010_0000,
    ST_FCSHI = 8'b0100_0000,
    ST_FLAG  = 8'b1000_0000
  } step_t;

  step_t       state, state_next, cur;
  logic        esc_done, esc_next;
  logic        out_valid;
  logic        fire;
  logic [7:0]  src;
  logic        src_esc;
  logic [7:0]  byte_next;
  logic        last_next;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b < ESC_XOR) || (b == ESC_BYTE) || (b == FLAG_BYTE);
  endfunction

  // Command start skips the header when the frame is already open.
  assign cur = (state == ST_HDR0 && !head_cmd.open) ? ST_DATA : state;

  always_comb begin
    case (cur)
      ST_FCSLO: src = head_cmd.fcs[7:0];
      ST_FCSHI: src = head_cmd.fcs[15:8];
      default:  src = head_cmd.data;
    endcase
  end
  assign src_esc = needs_esc(src);

  always_comb begin
    state_next = cur;
    esc_next   = 1'b0;
    byte_next  = FLAG_BYTE;
    last_next  = 1'b0;
    unique case (cur)
      ST_HDR0: begin
        byte_next  = FLAG_BYTE;
        state_next = ST_HDR1;
      end
      ST_HDR1: begin
        byte_next  = ADDR_BYTE;
        state_next = ST_HDR2;
      end
      ST_HDR2: begin
        byte_next  = ESC_BYTE;
        state_next = ST_HDR3;
      end
      ST_HDR3: begin
        byte_next  = CTRL_ESC;
        state_next = ST_DATA;
      end
      ST_DATA, ST_FCSLO, ST_FCSHI: begin
        if (src_esc && !esc_done) begin
          byte_next = ESC_BYTE;
          esc_next  = 1'b1;
        end else begin
          byte_next = src_esc ? (src ^ ESC_XOR) : src;
          if (cur == ST_DATA) begin
            state_next = head_cmd.last ? ST_FCSLO : ST_HDR0;
            last_next  = !head_cmd.last;
          end else if (cur == ST_FCSLO) begin
            state_next = ST_FCSHI;
          end else begin
            state_next = ST_FLAG;
          end
        end
      end
      ST_FLAG: begin
        byte_next  = FLAG_BYTE;
        state_next = ST_HDR0;
        last_next  = 1'b1;
      end
      default: begin
        state_next = ST_HDR0;
      end
    endcase
  end

  assign fire     = head_valid && (!out_valid || pop);
  assign head_pop = fire && last_next;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (fire) begin
      line_byte  <= byte_next;
      burst_last <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_HDR0;
      esc_done  <= 1'b0;
      out_valid <= 1'b0;
    end else if (fire) begin
      state     <= state_next;
      esc_done  <= esc_next;
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/pppfr_checker.sv */
// Port-level checks for the PPP async HDLC framer, bound to the top level.
// Depends on ppp_async_hdlc_framer ports only.
module pppfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] line_byte,
  input logic       burst_last
);

  // A waiting result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(line_byte) && $stable(burst_last)))
    else $error("result changed while waiting");

  // An escape octet never ends a request's burst.
  a_no_esc_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && burst_last) |-> (line_byte != 8'h7D))
    else $error("burst ends on escape byte");

  // Reset leaves the block empty and ready for requests.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("not empty after reset");

  // A popped escape octet is followed by a byte that is neither flag nor escape.
  a_esc_follow: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && line_byte == 8'h7D && !burst_last) |=>
      (empty || (line_byte != 8'h7E && line_byte != 8'h7D)))
    else $error("bad byte after escape");

endmodule

bind ppp_async_hdlc_framer pppfr_checker u_pppfr_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .line_byte  (line_byte),
  .burst_last (burst_last)
);

/* tb/sv/ppp_async_hdlc_framer_tb.sv */
// Self-checking testbench for ppp_async_hdlc_framer: a line-stream scoreboard
// predicts the framed, stuffed octets of every accepted payload request.
// Depends on pppfr_pkg for the line constants and the FCS seed.
module ppp_async_hdlc_framer_tb;
  import pppfr_pkg::*;

  // One octet of the line stream as the block presents it.
  typedef struct {
    logic [7:0] octet;
    logic       last;
  } line_t;

  // Scoreboard: keeps its own FCS and frame state, expands each accepted
  // payload request into the octets it must cause, and checks results in order.
  class line_scoreboard;
    line_t       pending_line[$];
    logic [15:0] running_fcs;
    bit          inside_frame;
    int unsigned error_count;

    function new();
      running_fcs  = FCS_SEED;
      inside_frame = 1'b0;
      error_count  = 0;
    endfunction

    // Reflected CRC-16 step over one byte, LSB first.
    static function logic [15:0] fcs16_update(logic [15:0] fcs, logic [7:0] b);
      logic [15:0] f;
      f = fcs;
      for (int i = 0; i < 8; i++) begin
        if (f[0] ^ b[i]) f = (f >> 1) ^ FCS_POLY;
        else f = f >> 1;
      end
      return f;
    endfunction

    static function bit needs_escape(logic [7:0] b);
      return (b < 8'h20) || (b == ESC_BYTE) || (b == FLAG_BYTE);
    endfunction

    function void stuff_octet(ref line_t burst[$], input logic [7:0] b);
      if (needs_escape(b)) begin
        burst.push_back('{ESC_BYTE, 1'b0});
        b = b ^ ESC_XOR;
      end
      burst.push_back('{b, 1'b0});
    endfunction

    function void note_payload(logic [7:0] b, logic frame_end);
      line_t       burst[$];
      logic [15:0] fcs_out;
      if (!inside_frame) begin
        burst.push_back('{FLAG_BYTE, 1'b0});
        burst.push_back('{ADDR_BYTE, 1'b0});
        burst.push_back('{ESC_BYTE, 1'b0});
        burst.push_back('{CTRL_ESC, 1'b0});
        inside_frame = 1'b1;
      end
      running_fcs = fcs16_update(running_fcs, b);
      stuff_octet(burst, b);
      if (frame_end) begin
        fcs_out = ~running_fcs;
        stuff_octet(burst, fcs_out[7:0]);
        stuff_octet(burst, fcs_out[15:8]);
        burst.push_back('{FLAG_BYTE, 1'b0});
        running_fcs  = FCS_SEED;
        inside_frame = 1'b0;
      end
      burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending_line.push_back(burst[i]);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      error_count++;
    endtask

    task check_line(logic [7:0] octet, logic last);
      line_t want;
      if (pending_line.size() == 0) begin
        report("unexpected line byte", octet, 8'h00);
      end else begin
        want = pending_line.pop_front();
        if (octet !== want.octet) report("line_byte", octet, want.octet);
        if (last !== want.last) report("burst_last", {7'b0, last}, {7'b0, want.last});
      end
    endtask

    function int pending();
      return pending_line.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] payload_byte;
  logic       frame_end;
  logic       empty;
  logic       pop;
  logic [7:0] line_byte;
  logic       burst_last;

  // Idle rates in percent of cycles; the main sequence changes them per phase.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  line_scoreboard sb;

  ppp_async_hdlc_framer u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .payload_byte (payload_byte),
    .frame_end    (frame_end),
    .empty        (empty),
    .pop          (pop),
    .line_byte    (line_byte),
    .burst_last   (burst_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Drop pop at random per cycle; hold it low through reset.
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Observe both handshakes at the edge. All values read here are the ones
  // held before the edge, since both sides update through nonblocking writes.
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (push === 1'b1 && full === 1'b0) sb.note_payload(payload_byte, frame_end);
      if (pop === 1'b1 && empty === 1'b0) sb.check_line(line_byte, burst_last);
    end
  end

  // Present one payload request and hold it until the block takes it.
  // Idle cycles go in front of the request so push is never lowered and
  // raised in the same step.
  task automatic send_request(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    payload_byte <= b;
    frame_end    <= last;
    do @(posedge clk); while (full !== 1'b0);
  endtask

  // Hold off the sender until every expected line byte has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Send whole frames of random length until about n requests have gone.
  // Most frames are short; a few run long. Three eighths of the bytes are drawn
  // from the ones that need stuffing.
  task automatic send_random_frames(input int n);
    int         sent;
    int         len;
    logic [7:0] b;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(7))
          0: b = ESC_BYTE;
          1: b = FLAG_BYTE;
          2: b = 8'($urandom_range(8'h1F, 8'h00));
          default: b = 8'($urandom_range(255));
        endcase
        send_request(b, i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    logic [15:0] fcs_out;
    int          esc_lo_byte;
    int          esc_hi_byte;

    sb           = new();
    tx_idle_pct  = 36;
    rx_idle_pct  = 54;
    rst          = 1'b1;
    push         = 1'b0;
    payload_byte = 8'h00;
    frame_end    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Find one-byte frames whose FCS low or high octet needs stuffing.
    esc_lo_byte = -1;
    esc_hi_byte = -1;
    for (int b = 0; b < 256; b++) begin
      fcs_out = ~line_scoreboard::fcs16_update(FCS_SEED, b[7:0]);
      if (esc_lo_byte < 0 && line_scoreboard::needs_escape(fcs_out[7:0])) esc_lo_byte = b;
      if (esc_hi_byte < 0 && line_scoreboard::needs_escape(fcs_out[15:8])) esc_hi_byte = b;
    end

    // Directed: one-byte frames at both extremes, then a frame that walks
    // every stuffing boundary, back-to-back frames, and stuffed FCS octets.
    send_request(8'h00, 1'b1);
    send_request(8'hFF, 1'b1);
    send_request(8'h7E, 1'b0);
    send_request(8'h7D, 1'b0);
    send_request(8'h1F, 1'b0);
    send_request(8'h20, 1'b0);
    send_request(8'h7C, 1'b0);
    send_request(8'h7F, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'hFE, 1'b0);
    send_request(8'h01, 1'b0);
    send_request(8'h55, 1'b0);
    send_request(8'hAA, 1'b1);
    send_request(8'hC0, 1'b0);
    send_request(8'h21, 1'b1);
    if (esc_lo_byte >= 0) send_request(esc_lo_byte[7:0], 1'b1);
    if (esc_hi_byte >= 0) send_request(esc_hi_byte[7:0], 1'b1);
    send_request(8'h03, 1'b0);
    send_request(8'h7E, 1'b1);
    // Pause the sender until the line has caught up completely.
    wait_drained();

    // Random phases: sender idles more lightly, then the other way round,
    // then neither side idles at all.
    send_random_frames(160);
    wait_drained();
    tx_idle_pct = 54;
    rx_idle_pct = 36;
    send_random_frames(160);
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_frames(160);
    wait_drained();

    // Let further edges pass so any stray line byte is caught.
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected line bytes left over", 8'h00, 8'h00);

    if (sb.error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Abort a run that hangs on a handshake.
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pppfr_pkg.sv
rtl/core/pppfr_front.sv
rtl/core/pppfr_queue.sv
rtl/core/pppfr_back.sv
rtl/core/ppp_async_hdlc_framer.sv
rtl/core/pppfr_checker.sv
tb/sv/ppp_async_hdlc_framer_tb.sv
